@@ rtl/tvm_pkg.sv @@
// Shared types and constants of the two-voice stereo sample mixer.
// No dependencies; used by the interfaces, the multiplier and the top level.
`timescale 1ns / 1ps

package tvm_pkg;

  // command codes
  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_TRIGGER = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_MASTER_GAIN   = 3'd0;
  localparam logic [2:0] REG_MUSIC_GAIN    = 3'd1;
  localparam logic [2:0] REG_EFFECT_GAIN   = 3'd2;
  localparam logic [2:0] REG_VOICE0_GAIN   = 3'd3;
  localparam logic [2:0] REG_VOICE1_GAIN   = 3'd4;
  localparam logic [2:0] REG_LOOP_MASK     = 3'd5;
  localparam logic [2:0] REG_VOICE0_LENGTH = 3'd6;
  localparam logic [2:0] REG_VOICE1_LENGTH = 3'd7;

  // gain limits, Q1.15
  localparam logic [15:0] GAIN_FLOOR = 16'd3;
  localparam logic [15:0] GAIN_ONE   = 16'd32768;

  // shared multiplier operand and product widths
  localparam int unsigned MUL_A_W = 33;
  localparam int unsigned MUL_B_W = 17;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  typedef struct packed {
    logic [1:0]         command;
    logic               voice_select;
    logic [11:0]        load_address;
    logic signed [15:0] load_left;
    logic signed [15:0] load_right;
  } tvm_in_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic [1:0]         playing_mask;
  } tvm_out_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [15:0] data;
  } tvm_cfg_t;

endpackage

@@ rtl/tvm_intf.sv @@
// Valid/ready channel interfaces of the mixer: input items, results, config writes.
// Depends on tvm_pkg for the payload types.
`timescale 1ns / 1ps

interface tvm_in_if;
  logic             valid;
  logic             ready;
  tvm_pkg::tvm_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tvm_out_if;
  logic              valid;
  logic              ready;
  tvm_pkg::tvm_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tvm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/tvm_mul.sv @@
// Shared signed multiplier of the mixer, product registered.
// Depends on tvm_pkg for operand widths.
`timescale 1ns / 1ps

module tvm_mul (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic signed [tvm_pkg::MUL_A_W-1:0]     op_a_i,
  input  logic signed [tvm_pkg::MUL_B_W-1:0]     op_b_i,
  output logic signed [tvm_pkg::MUL_P_W-1:0]     prod_o
);
  import tvm_pkg::*;

  logic signed [MUL_P_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= op_a_i * op_b_i;
    end
  end

  assign prod_o = prod_q;

endmodule

@@ rtl/tvm_store.sv @@
// Sample memory: one write port, one read port with registered read data.
// Entry holds left sample in the low half and right sample in the high half.
`timescale 1ns / 1ps

module tvm_store #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned AW    = 13
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [31:0]   wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [31:0]   rd_data_o
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/two_voice_stereo_sample_mixer.sv @@
// Two-voice stereo sample mixer, top level: sequencer, voice state, config registers.
// Load and trigger act on accept and leave the sequencer idle. A tick steps through the
// voices and then hands one result to the output; all gain and sample products go through
// one shared multiplier, four products per playing voice.
// The input is not ready during a tick; one result waits in the output register.
// Reset (rst_ni low, async): positions zero, voice 0 playing, registers to defaults.
`timescale 1ns / 1ps

module two_voice_stereo_sample_mixer #(
  parameter int unsigned FRAMES_PER_VOICE = 4096,
  parameter int unsigned NUM_VOICES       = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  tvm_in_if.sink    in_if,
  tvm_out_if.source out_if,
  tvm_cfg_if.sink   cfg_if
);
  import tvm_pkg::*;

  // position width, length compare width, voice index width
  localparam int unsigned PW    = $clog2(FRAMES_PER_VOICE);
  localparam int unsigned LW    = (PW + 1 > 13) ? PW + 1 : 13;
  localparam int unsigned VW    = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int unsigned SAW   = VW + PW;
  localparam int unsigned DEPTH = NUM_VOICES << PW;
  // each contribution is below 2^31 in magnitude; room for all voices plus rounding
  localparam int unsigned ACC_W = 34 + VW;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_VOICE = 3'd1;  // read frame, master * category
  localparam logic [2:0] S_MC    = 3'd2;  // times voice gain
  localparam logic [2:0] S_G     = 3'd3;  // round combined gain
  localparam logic [2:0] S_L     = 3'd4;  // left sample * gain
  localparam logic [2:0] S_R     = 3'd5;  // right sample * gain, add left
  localparam logic [2:0] S_ACC   = 3'd6;  // add right, advance position
  localparam logic [2:0] S_DONE  = 3'd7;  // round, saturate, hand to output

  // ---------------- configuration registers ----------------
  logic [15:0] master_gain_q, music_gain_q, effect_gain_q, voice0_gain_q, voice1_gain_q;
  logic [1:0]  loop_mask_q;
  logic [12:0] voice0_length_q, voice1_length_q;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_gain_q   <= 16'd3277;
      music_gain_q    <= 16'd32768;
      effect_gain_q   <= 16'd32768;
      voice0_gain_q   <= 16'd6554;
      voice1_gain_q   <= 16'd26214;
      loop_mask_q     <= 2'd1;
      voice0_length_q <= 13'd4096;
      voice1_length_q <= 13'd4096;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_MASTER_GAIN:   master_gain_q   <= cfg_if.data;
        REG_MUSIC_GAIN:    music_gain_q    <= cfg_if.data;
        REG_EFFECT_GAIN:   effect_gain_q   <= cfg_if.data;
        REG_VOICE0_GAIN:   voice0_gain_q   <= cfg_if.data;
        REG_VOICE1_GAIN:   voice1_gain_q   <= cfg_if.data;
        REG_LOOP_MASK:     loop_mask_q     <= cfg_if.data[1:0];
        REG_VOICE0_LENGTH: voice0_length_q <= cfg_if.data[12:0];
        REG_VOICE1_LENGTH: voice1_length_q <= cfg_if.data[12:0];
        default: ;
      endcase
    end
  end

  // ---------------- sequencer and voice state ----------------
  logic [2:0]              state_q, state_d;
  logic [VW-1:0]           vox_q, vox_d;
  logic [PW-1:0]           pos_q [NUM_VOICES];
  logic [NUM_VOICES-1:0]   playing_q;
  logic signed [ACC_W-1:0] acc_l_q, acc_l_d, acc_r_q, acc_r_d;
  logic [16:0]             g_q;
  logic                    out_valid_q;
  tvm_out_t                out_data_q;

  logic in_fire;
  logic sel_ok, addr_ok;
  logic [VW-1:0] sel_idx;

  assign in_if.ready = (state_q == S_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign sel_ok      = 32'(in_if.data.voice_select) < 32'(NUM_VOICES);
  assign addr_ok     = 32'(in_if.data.load_address) < 32'(FRAMES_PER_VOICE);
  assign sel_idx     = VW'(in_if.data.voice_select);

  // per-voice settings of the voice being mixed; voices past 0 take the effect gain and voice 1 settings
  logic [15:0]   m_clamp, c_raw, c_clamp, vg_raw, vg_clamp;
  logic [12:0]   len_raw;
  logic [LW-1:0] len_ext, len_clamp, pos_inc;
  logic          loops;
  logic          is_v0, last_vox;

  assign is_v0    = (vox_q == '0);
  assign last_vox = (vox_q == VW'(NUM_VOICES - 1));
  assign c_raw    = is_v0 ? music_gain_q    : effect_gain_q;
  assign vg_raw   = is_v0 ? voice0_gain_q   : voice1_gain_q;
  assign len_raw  = is_v0 ? voice0_length_q : voice1_length_q;
  assign loops    = (32'(vox_q) < 32'd2) && loop_mask_q[vox_q[0]];

  always_comb begin
    m_clamp = master_gain_q;
    if (master_gain_q < GAIN_FLOOR) m_clamp = GAIN_FLOOR;
    if (master_gain_q > GAIN_ONE)   m_clamp = GAIN_ONE;
    c_clamp = c_raw;
    if (c_raw < GAIN_FLOOR) c_clamp = GAIN_FLOOR;
    if (c_raw > GAIN_ONE)   c_clamp = GAIN_ONE;
    vg_clamp = (vg_raw > GAIN_ONE) ? GAIN_ONE : vg_raw;
    len_ext   = LW'(len_raw);
    len_clamp = len_ext;
    if (len_ext == '0) len_clamp = LW'(1);
    if (len_ext > LW'(FRAMES_PER_VOICE)) len_clamp = LW'(FRAMES_PER_VOICE);
  end

  assign pos_inc = LW'(pos_q[vox_q]) + LW'(1);

  // ---------------- sample memory ----------------
  logic [31:0] frame;

  tvm_store #(
    .DEPTH (DEPTH),
    .AW    (SAW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (in_fire && (in_if.data.command == CMD_LOAD) && sel_ok && addr_ok),
    .wr_addr_i ({sel_idx, PW'(in_if.data.load_address)}),
    .wr_data_i ({in_if.data.load_right, in_if.data.load_left}),
    .rd_en_i   (state_q == S_VOICE),
    .rd_addr_i ({vox_q, pos_q[vox_q]}),
    .rd_data_o (frame)
  );

  // ---------------- shared multiplier ----------------
  logic signed [MUL_A_W-1:0] op_a;
  logic signed [MUL_B_W-1:0] op_b;
  logic signed [MUL_P_W-1:0] prod;
  logic                      mul_en;
  logic [46:0]               g_sum;

  always_comb begin
    op_a   = '0;
    op_b   = '0;
    mul_en = 1'b0;
    case (state_q)
      S_VOICE: begin
        op_a   = MUL_A_W'(m_clamp);
        op_b   = MUL_B_W'(c_clamp);
        mul_en = playing_q[vox_q];
      end
      S_MC: begin
        op_a   = prod[MUL_A_W-1:0];
        op_b   = MUL_B_W'(vg_clamp);
        mul_en = 1'b1;
      end
      S_L: begin
        op_a   = MUL_A_W'($signed(frame[15:0]));
        op_b   = g_q;
        mul_en = 1'b1;
      end
      S_R: begin
        op_a   = MUL_A_W'($signed(frame[31:16]));
        op_b   = g_q;
        mul_en = 1'b1;
      end
      default: ;
    endcase
  end

  tvm_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod)
  );

  // combined gain: round the Q.45 product of three Q1.15 gains to Q1.15
  assign g_sum = prod[46:0] + (47'd1 << 29);

  always_ff @(posedge clk_i) begin
    if (state_q == S_G) begin
      g_q <= g_sum[46:30];
    end
  end

  // ---------------- round and saturate ----------------
  logic signed [ACC_W-1:0] rnd_l, rnd_r;
  logic signed [15:0]      sat_l, sat_r;
  logic [1:0]              mask;

  assign rnd_l = (acc_l_q + ACC_W'(16384)) >>> 15;
  assign rnd_r = (acc_r_q + ACC_W'(16384)) >>> 15;

  always_comb begin
    sat_l = rnd_l[15:0];
    if (rnd_l > ACC_W'(32767))                 sat_l = 16'sh7fff;
    if (rnd_l < -$signed(ACC_W'(32768)))       sat_l = 16'sh8000;
    sat_r = rnd_r[15:0];
    if (rnd_r > ACC_W'(32767))                 sat_r = 16'sh7fff;
    if (rnd_r < -$signed(ACC_W'(32768)))       sat_r = 16'sh8000;
    mask    = '0;
    mask[0] = playing_q[0];
    if (NUM_VOICES > 1) mask[1] = playing_q[NUM_VOICES > 1 ? 1 : 0];
  end

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    vox_d   = vox_q;
    acc_l_d = acc_l_q;
    acc_r_d = acc_r_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire && (in_if.data.command == CMD_TICK)) begin
          state_d = S_VOICE;
          vox_d   = '0;
          acc_l_d = '0;
          acc_r_d = '0;
        end
      end
      S_VOICE: begin
        if (playing_q[vox_q]) begin
          state_d = S_MC;
        end else if (last_vox) begin
          state_d = S_DONE;
        end else begin
          vox_d = vox_q + VW'(1);
        end
      end
      S_MC: state_d = S_G;
      S_G:  state_d = S_L;
      S_L:  state_d = S_R;
      S_R: begin
        acc_l_d = acc_l_q + ACC_W'($signed(prod[32:0]));
        state_d = S_ACC;
      end
      S_ACC: begin
        acc_r_d = acc_r_q + ACC_W'($signed(prod[32:0]));
        if (last_vox) begin
          state_d = S_DONE;
        end else begin
          vox_d   = vox_q + VW'(1);
          state_d = S_VOICE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_if.ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vox_q   <= '0;
    end else begin
      state_q <= state_d;
      vox_q   <= vox_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_l_q <= acc_l_d;
    acc_r_q <= acc_r_d;
  end

  // positions and playing flags: trigger from the input, advance at the end of a voice
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < NUM_VOICES; v++) begin
        pos_q[v]     <= '0;
        playing_q[v] <= (v == 0);
      end
    end else if (in_fire && (in_if.data.command == CMD_TRIGGER) && sel_ok) begin
      pos_q[sel_idx]     <= '0;
      playing_q[sel_idx] <= 1'b1;
    end else if (state_q == S_ACC) begin
      if (pos_inc >= len_clamp) begin
        pos_q[vox_q] <= '0;
        if (!loops) playing_q[vox_q] <= 1'b0;
      end else begin
        pos_q[vox_q] <= pos_inc[PW-1:0];
      end
    end
  end

  // ---------------- output register ----------------
  logic out_load;
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_if.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.left_out     <= sat_l;
      out_data_q.right_out    <= sat_r;
      out_data_q.playing_mask <= mask;
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_data_q;

endmodule
